/* rtl/core/tvp_pkg.sv */
`timescale 1ns / 1ps
// Package for the tile video port and line fetch core.
// Holds codes, sizes, controller states and the command/status structs.
// No dependencies.
package tvp_pkg;

   localparam int VRAM_BYTES   = 16384;
   localparam int VRAM_AW      = $clog2(VRAM_BYTES);
   localparam int CRAM_ENTRIES = 32;
   localparam int CRAM_AW      = $clog2(CRAM_ENTRIES);
   localparam int PIX_W        = 6;

   localparam logic [VRAM_AW-1:0] VRAM_LAST = VRAM_AW'(VRAM_BYTES - 1);
   localparam logic [4:0]          COL_LAST  = 5'd31;
   localparam logic [3:0]          PLANE_END = 4'd4;
   localparam logic [3:0]          PIX_END   = 4'd8;

   // Input operations
   localparam logic [1:0] OP_CTRL   = 2'd0;
   localparam logic [1:0] OP_DATA   = 2'd1;
   localparam logic [1:0] OP_RENDER = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_ACK = 2'd0;
   localparam logic [1:0] KIND_REG = 2'd1;
   localparam logic [1:0] KIND_SEG = 2'd2;

   // Access codes from the second control byte
   localparam logic [1:0] CODE_READ = 2'd0;
   localparam logic [1:0] CODE_REGW = 2'd2;
   localparam logic [1:0] CODE_CRAM = 2'd3;

   typedef enum logic [2:0] {
      VSEL_CLEAR   = 3'd0,
      VSEL_PORT    = 3'd1,
      VSEL_NAME_LO = 3'd2,
      VSEL_NAME_HI = 3'd3,
      VSEL_PLANE   = 3'd4
   } vsel_type;

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b0000000001,
      ST_IDLE    = 10'b0000000010,
      ST_EXEC    = 10'b0000000100,
      ST_PREF    = 10'b0000001000,
      ST_EMIT    = 10'b0000010000,
      ST_NAME_LO = 10'b0000100000,
      ST_NAME_HI = 10'b0001000000,
      ST_ENTRY   = 10'b0010000000,
      ST_PLANE   = 10'b0100000000,
      ST_SEG_PIX = 10'b1000000000
   } state_type;

   typedef struct packed {
      vsel_type            vsel;
      logic                clear;
      logic                capture;
      logic                exec;
      logic                pref;
      logic                cap_lo;
      logic                cap_hi;
      logic                cap_plane;
      logic                cap_pix;
      logic                load_port;
      logic                load_seg;
      logic                last;
      logic [VRAM_AW-1:0]  clr_addr;
      logic [4:0]          col;
      logic [1:0]          sub;
      logic [1:0]          plane_idx;
      logic [2:0]          pix_rd;
      logic [2:0]          pix_idx;
   } tvp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       pending;
      logic [1:0] value_code;
      logic       rsp_free;
   } tvp_stat_type;

endpackage

/* rtl/core/tvp_if.sv */
`timescale 1ns / 1ps
// Channel interfaces for the tile video port and line fetch core.
// Depends on tvp_pkg for field widths.
interface tvp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] value;
   logic [7:0] line;
   modport source (output valid, output op, output value, output line, input ready);
   modport sink   (input valid, input op, input value, input line, output ready);
endinterface

interface tvp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic [3:0]                reg_index;
   logic [7:0]                byte_value;
   logic [tvp_pkg::PIX_W-1:0] pix0;
   logic [tvp_pkg::PIX_W-1:0] pix1;
   logic [tvp_pkg::PIX_W-1:0] pix2;
   logic [tvp_pkg::PIX_W-1:0] pix3;
   logic [tvp_pkg::PIX_W-1:0] pix4;
   logic [tvp_pkg::PIX_W-1:0] pix5;
   logic [tvp_pkg::PIX_W-1:0] pix6;
   logic [tvp_pkg::PIX_W-1:0] pix7;
   logic                      last;
   modport source (output valid, output kind, output reg_index, output byte_value,
                   output pix0, output pix1, output pix2, output pix3,
                   output pix4, output pix5, output pix6, output pix7,
                   output last, input ready);
   modport sink   (input valid, input kind, input reg_index, input byte_value,
                   input pix0, input pix1, input pix2, input pix3,
                   input pix4, input pix5, input pix6, input pix7,
                   input last, output ready);
endinterface

/* rtl/core/tvp_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module tvp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

/* rtl/core/tvp_datapath.sv */
`timescale 1ns / 1ps
// Datapath: port state, VRAM and CRAM, tile decode registers, result register.
// Depends on tvp_pkg, tvp_if and tvp_ram.
module tvp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_op,
   input  logic [7:0]           req_value,
   input  logic [7:0]           req_line,
   input  tvp_pkg::tvp_cmd_type cmd,
   output tvp_pkg::tvp_stat_type stat,
   tvp_rsp_if.source            rsp
);
   logic [1:0]                  op_ff;
   logic [7:0]                  value_ff;
   logic [7:0]                  line_ff;
   logic                        pending_ff, pending_in;
   logic [1:0]                  code_ff, code_in;
   logic [tvp_pkg::VRAM_AW-1:0] addr_ff, addr_in;
   logic [7:0]                  latch_ff, latch_in;
   logic [1:0]                  kind_ff, kind_in;
   logic [9:0]                  entry_ff;
   logic [7:0]                  planes_ff [4];
   logic [tvp_pkg::PIX_W-1:0]   pix_ff [8];

   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_kind_ff;
   logic [3:0]                  rsp_reg_ff;
   logic [7:0]                  rsp_byte_ff;
   logic [tvp_pkg::PIX_W-1:0]   rsp_pix_ff [8];
   logic                        rsp_last_ff;

   logic                        vram_we;
   logic [tvp_pkg::VRAM_AW-1:0] vram_addr;
   logic [7:0]                  vram_wdata;
   logic [7:0]                  vram_rdata;
   logic                        cram_we;
   logic [tvp_pkg::CRAM_AW-1:0] cram_addr;
   logic [tvp_pkg::PIX_W-1:0]   cram_wdata;
   logic [tvp_pkg::PIX_W-1:0]   cram_rdata;

   logic [4:0]                  row;
   logic [2:0]                  fine;
   logic [2:0]                  bit_sel;
   logic [3:0]                  color_idx;
   logic                        data_to_cram;

   assign row          = line_ff[7:3];
   assign fine         = line_ff[2:0];
   assign data_to_cram = (op_ff == tvp_pkg::OP_DATA) && (code_ff == tvp_pkg::CODE_CRAM);
   assign bit_sel      = entry_ff[9] ? cmd.pix_rd : 3'd7 - cmd.pix_rd;
   assign color_idx    = {planes_ff[3][bit_sel], planes_ff[2][bit_sel],
                          planes_ff[1][bit_sel], planes_ff[0][bit_sel]};

   // VRAM port select
   always_comb begin
      vram_we    = 1'b0;
      vram_wdata = 8'd0;
      vram_addr  = addr_ff;
      unique case (cmd.vsel)
         tvp_pkg::VSEL_CLEAR: begin
            vram_we   = cmd.clear;
            vram_addr = cmd.clr_addr;
         end
         tvp_pkg::VSEL_PORT: begin
            if (op_ff == tvp_pkg::OP_DATA) begin
               vram_we    = cmd.exec && !data_to_cram;
               vram_wdata = value_ff;
               vram_addr  = addr_ff;
            end else begin
               // prefetch reads at the address the second byte forms
               vram_addr = {value_ff[5:0], addr_ff[7:0]};
            end
         end
         tvp_pkg::VSEL_NAME_LO: vram_addr = {3'b111, row, cmd.col, 1'b0};
         tvp_pkg::VSEL_NAME_HI: vram_addr = {3'b111, row, cmd.col, 1'b1};
         tvp_pkg::VSEL_PLANE:   vram_addr = {entry_ff[8:0], fine, cmd.sub};
         default:               vram_addr = addr_ff;
      endcase
   end

   always_comb begin
      cram_we    = 1'b0;
      cram_wdata = '0;
      cram_addr  = {1'b0, color_idx};
      if (cmd.clear) begin
         cram_we   = 1'b1;
         cram_addr = cmd.clr_addr[tvp_pkg::CRAM_AW-1:0];
      end else if (cmd.exec && data_to_cram) begin
         cram_we    = 1'b1;
         cram_addr  = addr_ff[tvp_pkg::CRAM_AW-1:0];
         cram_wdata = value_ff[tvp_pkg::PIX_W-1:0];
      end
   end

   tvp_ram #(.WIDTH(8), .DEPTH(tvp_pkg::VRAM_BYTES)) u_vram (
      .clock (clock),
      .we    (vram_we),
      .addr  (vram_addr),
      .wdata (vram_wdata),
      .rdata (vram_rdata)
   );

   tvp_ram #(.WIDTH(tvp_pkg::PIX_W), .DEPTH(tvp_pkg::CRAM_ENTRIES)) u_cram (
      .clock (clock),
      .we    (cram_we),
      .addr  (cram_addr),
      .wdata (cram_wdata),
      .rdata (cram_rdata)
   );

   // Port state update
   always_comb begin
      pending_in = pending_ff;
      code_in    = code_ff;
      addr_in    = addr_ff;
      latch_in   = latch_ff;
      kind_in    = kind_ff;
      if (cmd.exec) begin
         kind_in = tvp_pkg::KIND_ACK;
         unique case (op_ff)
            tvp_pkg::OP_CTRL: begin
               if (!pending_ff) begin
                  addr_in    = {addr_ff[13:8], value_ff};
                  pending_in = 1'b1;
               end else begin
                  addr_in    = {value_ff[5:0], addr_ff[7:0]};
                  pending_in = 1'b0;
                  code_in    = value_ff[7:6];
                  if (value_ff[7:6] == tvp_pkg::CODE_REGW) begin
                     kind_in = tvp_pkg::KIND_REG;
                  end
               end
            end
            tvp_pkg::OP_DATA: begin
               latch_in   = value_ff;
               pending_in = 1'b0;
               addr_in    = addr_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end else if (cmd.pref) begin
         latch_in = vram_rdata;
         addr_in  = addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         code_ff    <= 2'd0;
         addr_ff    <= '0;
         latch_ff   <= 8'd0;
      end else begin
         pending_ff <= pending_in;
         code_ff    <= code_in;
         addr_ff    <= addr_in;
         latch_ff   <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      if (cmd.capture) begin
         op_ff    <= req_op;
         value_ff <= req_value;
         line_ff  <= req_line;
      end
      if (cmd.cap_lo) begin
         entry_ff[7:0] <= vram_rdata;
      end
      if (cmd.cap_hi) begin
         entry_ff[9:8] <= vram_rdata[1:0];
      end
      if (cmd.cap_plane) begin
         planes_ff[cmd.plane_idx] <= vram_rdata;
      end
      if (cmd.cap_pix) begin
         pix_ff[cmd.pix_idx] <= cram_rdata;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_port || cmd.load_seg) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_port) begin
         rsp_kind_ff <= kind_ff;
         rsp_last_ff <= 1'b1;
         if (kind_ff == tvp_pkg::KIND_REG) begin
            rsp_reg_ff  <= addr_ff[11:8];
            rsp_byte_ff <= addr_ff[7:0];
         end else begin
            rsp_reg_ff  <= 4'd0;
            rsp_byte_ff <= latch_ff;
         end
         for (int i = 0; i < 8; i++) begin
            rsp_pix_ff[i] <= '0;
         end
      end else if (cmd.load_seg) begin
         rsp_kind_ff <= tvp_pkg::KIND_SEG;
         rsp_last_ff <= cmd.last;
         rsp_reg_ff  <= 4'd0;
         rsp_byte_ff <= latch_ff;
         for (int i = 0; i < 8; i++) begin
            rsp_pix_ff[i] <= pix_ff[i];
         end
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = rsp_kind_ff;
   assign rsp.reg_index  = rsp_reg_ff;
   assign rsp.byte_value = rsp_byte_ff;
   assign rsp.pix0       = rsp_pix_ff[0];
   assign rsp.pix1       = rsp_pix_ff[1];
   assign rsp.pix2       = rsp_pix_ff[2];
   assign rsp.pix3       = rsp_pix_ff[3];
   assign rsp.pix4       = rsp_pix_ff[4];
   assign rsp.pix5       = rsp_pix_ff[5];
   assign rsp.pix6       = rsp_pix_ff[6];
   assign rsp.pix7       = rsp_pix_ff[7];
   assign rsp.last       = rsp_last_ff;

   assign stat.op         = op_ff;
   assign stat.pending    = pending_ff;
   assign stat.value_code = value_ff[7:6];
   assign stat.rsp_free   = !rsp_valid_ff || rsp.ready;
endmodule

/* rtl/core/tvp_ctrl.sv */
`timescale 1ns / 1ps
// Controller: clearing pass, port sequencing and tile fetch sequencing.
// Depends on tvp_pkg.
module tvp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tvp_pkg::tvp_stat_type stat,
   output tvp_pkg::tvp_cmd_type  cmd
);
   tvp_pkg::state_type          state_ff, state_in;
   logic [4:0]                  col_ff, col_in;
   logic [3:0]                  step_ff, step_in;
   logic [tvp_pkg::VRAM_AW-1:0] clr_ff, clr_in;

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      step_in       = step_ff;
      clr_in        = clr_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.vsel      = tvp_pkg::VSEL_PORT;
      cmd.clr_addr  = clr_ff;
      cmd.col       = col_ff;
      cmd.sub       = step_ff[1:0];
      cmd.plane_idx = step_ff[1:0] - 2'd1;
      cmd.pix_rd    = step_ff[2:0];
      cmd.pix_idx   = step_ff[2:0] - 3'd1;
      unique case (state_ff)
         tvp_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.vsel  = tvp_pkg::VSEL_CLEAR;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == tvp_pkg::VRAM_LAST) begin
               state_in = tvp_pkg::ST_IDLE;
            end
         end
         tvp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = tvp_pkg::ST_EXEC;
            end
         end
         tvp_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            priority if (stat.op == tvp_pkg::OP_RENDER) begin
               col_in   = 5'd0;
               state_in = tvp_pkg::ST_NAME_LO;
            end else if (stat.op == tvp_pkg::OP_CTRL && stat.pending
                         && stat.value_code == tvp_pkg::CODE_READ) begin
               state_in = tvp_pkg::ST_PREF;
            end else begin
               state_in = tvp_pkg::ST_EMIT;
            end
         end
         tvp_pkg::ST_PREF: begin
            cmd.pref = 1'b1;
            state_in = tvp_pkg::ST_EMIT;
         end
         tvp_pkg::ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.load_port = 1'b1;
               state_in      = tvp_pkg::ST_IDLE;
            end
         end
         tvp_pkg::ST_NAME_LO: begin
            cmd.vsel = tvp_pkg::VSEL_NAME_LO;
            state_in = tvp_pkg::ST_NAME_HI;
         end
         tvp_pkg::ST_NAME_HI: begin
            cmd.vsel   = tvp_pkg::VSEL_NAME_HI;
            cmd.cap_lo = 1'b1;
            state_in   = tvp_pkg::ST_ENTRY;
         end
         tvp_pkg::ST_ENTRY: begin
            cmd.cap_hi = 1'b1;
            step_in    = 4'd0;
            state_in   = tvp_pkg::ST_PLANE;
         end
         tvp_pkg::ST_PLANE: begin
            cmd.vsel      = tvp_pkg::VSEL_PLANE;
            cmd.cap_plane = (step_ff != 4'd0);
            if (step_ff == tvp_pkg::PLANE_END) begin
               step_in  = 4'd0;
               state_in = tvp_pkg::ST_SEG_PIX;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         tvp_pkg::ST_SEG_PIX: begin
            // steps 0..8 read CRAM per pixel, step 9 hands out the segment once the result register is free
            if (step_ff <= tvp_pkg::PIX_END) begin
               cmd.cap_pix = (step_ff != 4'd0);
               step_in     = step_ff + 4'd1;
            end else if (stat.rsp_free) begin
               cmd.load_seg = 1'b1;
               cmd.last     = (col_ff == tvp_pkg::COL_LAST);
               if (col_ff == tvp_pkg::COL_LAST) begin
                  state_in = tvp_pkg::ST_IDLE;
               end else begin
                  col_in   = col_ff + 5'd1;
                  state_in = tvp_pkg::ST_NAME_LO;
               end
            end
         end
         default: begin
            state_in = tvp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvp_pkg::ST_CLEAR;
         col_ff   <= 5'd0;
         step_ff  <= 4'd0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         step_ff  <= step_in;
         clr_ff   <= clr_in;
      end
   end
endmodule

/* rtl/core/tile_video_port_and_line_fetch_core.sv */
`timescale 1ns / 1ps
// Tile video port and mode-4 background line fetch, top level.
// Port path: IDLE captures a request, EXEC applies it, PREF prefetches for a read,
// EMIT loads the result register once free. One port transaction at a time; a line
// render emits 32 tile segments via the single VRAM/CRAM read ports.
// Reset: synchronous; after reset a clearing pass writes zero to VRAM and CRAM,
// during which no request is taken.
// Depends on tvp_pkg, tvp_if, tvp_ram, tvp_datapath and tvp_ctrl.
module tile_video_port_and_line_fetch_core (
   input  logic      clock,
   input  logic      reset,
   tvp_req_if.sink   req_port,
   tvp_rsp_if.source rsp_port
);
   tvp_pkg::tvp_cmd_type  cmd;
   tvp_pkg::tvp_stat_type stat;

   // Controller sequences everything: one request transaction at a time.
   tvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath holds the port state, both memories and the result register,
   // so a finished result can wait while the next request is taken.
   tvp_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_op    (req_port.op),
      .req_value (req_port.value),
      .req_line  (req_port.line),
      .cmd       (cmd),
      .stat      (stat),
      .rsp       (rsp_port)
   );

`ifndef ASSERT_OFF
   // clearing pass blocks requests right after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_port.ready)
      else $error("request taken during clearing pass");

   // one request in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("request taken while another is in progress");

   // only segments can be non-final results
   a_non_last_is_seg: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.last) |-> (rsp_port.kind == tvp_pkg::KIND_SEG))
      else $error("non-final result that is not a segment");

   // register write results carry no pixels
   a_reg_no_pix: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.kind == tvp_pkg::KIND_REG) |-> (rsp_port.pix0 == '0))
      else $error("register write result carries pixel data");
`endif
endmodule

/* tb/tile_video_port_and_line_fetch_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for tile_video_port_and_line_fetch_core: port writes,
// register requests, VRAM/CRAM loads and line renders against a behavioral model.
// Depends on tvp_pkg, tvp_if and the core RTL.
module tile_video_port_and_line_fetch_core_tb;

   // op and code values the package does not name
   localparam logic [1:0] OP_NOP     = 2'd3;
   localparam logic [1:0] CODE_VRAMW = 2'd1;
   localparam logic [13:0] NAME_BASE = 14'h3800;
   localparam int N_RANDOM   = 460;
   localparam int IDLE_LIMIT = 50000;  // covers the post-reset clear pass
   localparam int HOLD_LEN   = 3000;   // long receiver hold-off

   typedef struct packed {
      logic [1:0]                     kind;
      logic [3:0]                     reg_index;
      logic [7:0]                     byte_value;
      logic [7:0][tvp_pkg::PIX_W-1:0] pix;     // pix[0] is leftmost
      logic                           last;
   } video_rsp_type;

   typedef struct {
      logic [1:0]    op;
      logic [7:0]    value;
      logic [7:0]    line;
      bit            typed;     // expectation given directly in the table
      video_rsp_type typed_rsp;
   } port_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tvp_req_if req_if ();
   tvp_rsp_if rsp_if ();

   tile_video_port_and_line_fetch_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow copy of the core state, updated on each accepted request
   // ---------------------------------------------------------------------------
   logic        sh_pending;
   logic [1:0]  sh_code;
   logic [13:0] sh_addr;
   logic [7:0]  sh_latch;
   logic [7:0]  sh_vram [tvp_pkg::VRAM_BYTES];
   logic [5:0]  sh_cram [tvp_pkg::CRAM_ENTRIES];

   video_rsp_type  pending_rsp [$];   // results owed by the core, oldest first
   port_item_type  stim [$];
   int             n_directed;

   int sent = 0, n_req = 0, n_rsp = 0, n_renders = 0, n_regw = 0;
   int errors = 0, idle_cycles = 0;

   function automatic video_rsp_type port_rsp(logic [1:0] kind, logic [3:0] ri,
                                              logic [7:0] b);
      video_rsp_type r;
      r = '0;
      r.kind       = kind;
      r.reg_index  = ri;
      r.byte_value = b;
      r.last       = 1'b1;
      return r;
   endfunction

   // builds the 32 tile segments of one background line
   task automatic fetch_line(input logic [7:0] line);
      logic [4:0]    row;
      logic [2:0]    fine;
      logic [13:0]   na, pat;
      logic [15:0]   entry;
      logic [7:0]    planes [4];
      logic [3:0]    idx;
      int            bit_n;
      video_rsp_type r;
      row  = line[7:3];
      fine = line[2:0];
      for (int col = 0; col < 32; col++) begin
         na    = NAME_BASE | (14'(row) << 6) | (14'(col) << 1);
         entry = {sh_vram[na + 14'd1], sh_vram[na]};
         pat   = {entry[8:0], fine, 2'b00};
         for (int b = 0; b < 4; b++) planes[b] = sh_vram[pat + 14'(b)];
         r            = '0;
         r.kind       = tvp_pkg::KIND_SEG;
         r.byte_value = sh_latch;
         for (int p = 0; p < 8; p++) begin
            bit_n = entry[9] ? p : 7 - p;   // horizontal flip mirrors the row
            for (int b = 0; b < 4; b++) idx[b] = planes[b][bit_n];
            r.pix[p] = sh_cram[idx];
         end
         r.last = (col == 31);
         pending_rsp.push_back(r);
      end
   endtask

   task automatic apply_request(input port_item_type it);
      video_rsp_type r;
      r = port_rsp(tvp_pkg::KIND_ACK, 4'd0, 8'd0);
      case (it.op)
         tvp_pkg::OP_CTRL: begin
            if (!sh_pending) begin
               sh_addr    = {sh_addr[13:8], it.value};
               sh_pending = 1'b1;
               r = port_rsp(tvp_pkg::KIND_ACK, 4'd0, sh_latch);
            end else begin
               sh_pending = 1'b0;
               sh_addr    = {it.value[5:0], sh_addr[7:0]};
               sh_code    = it.value[7:6];
               if (sh_code == tvp_pkg::CODE_READ) begin
                  sh_latch = sh_vram[sh_addr];
                  sh_addr  = sh_addr + 14'd1;
               end
               if (sh_code == tvp_pkg::CODE_REGW)
                  r = port_rsp(tvp_pkg::KIND_REG, sh_addr[11:8], sh_addr[7:0]);
               else
                  r = port_rsp(tvp_pkg::KIND_ACK, 4'd0, sh_latch);
            end
         end
         tvp_pkg::OP_DATA: begin
            sh_latch   = it.value;
            sh_pending = 1'b0;
            if (sh_code == tvp_pkg::CODE_CRAM) sh_cram[sh_addr[4:0]] = it.value[5:0];
            else sh_vram[sh_addr] = it.value;
            sh_addr = sh_addr + 14'd1;
            r = port_rsp(tvp_pkg::KIND_ACK, 4'd0, sh_latch);
         end
         tvp_pkg::OP_RENDER: begin
            n_renders++;
            fetch_line(it.line);
         end
         default: r = port_rsp(tvp_pkg::KIND_ACK, 4'd0, sh_latch);  // unused op: ack only
      endcase
      if (it.op != tvp_pkg::OP_RENDER) begin
         if (r.kind == tvp_pkg::KIND_REG) n_regw++;
         pending_rsp.push_back(it.typed ? it.typed_rsp : r);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------------
   task automatic add(input logic [1:0] op, input logic [7:0] v, input logic [7:0] l);
      port_item_type it;
      it.op = op; it.value = v; it.line = l; it.typed = 1'b0; it.typed_rsp = '0;
      stim.push_back(it);
   endtask

   task automatic add_typed(input logic [1:0] op, input logic [7:0] v,
                            input logic [1:0] kind, input logic [3:0] ri,
                            input logic [7:0] b);
      port_item_type it;
      it.op = op; it.value = v; it.line = 8'd0; it.typed = 1'b1;
      it.typed_rsp = port_rsp(kind, ri, b);
      stim.push_back(it);
   endtask

   // full two-byte control sequence
   task automatic set_addr(input logic [13:0] a, input logic [1:0] code);
      add(tvp_pkg::OP_CTRL, a[7:0], 8'($urandom));
      add(tvp_pkg::OP_CTRL, {code, a[13:8]}, 8'($urandom));
   endtask

   task automatic build_directed();
      // directed table: typed rows are exact after reset, the rest use the model
      add_typed(tvp_pkg::OP_CTRL, 8'h00, tvp_pkg::KIND_ACK, 4'd0, 8'h00);
      add_typed(tvp_pkg::OP_CTRL, 8'h80, tvp_pkg::KIND_REG, 4'd0, 8'h00);   // reg 0 <- 0
      add_typed(tvp_pkg::OP_CTRL, 8'hFF, tvp_pkg::KIND_ACK, 4'd0, 8'h00);
      add_typed(tvp_pkg::OP_CTRL, 8'hBF, tvp_pkg::KIND_REG, 4'hF, 8'hFF);   // top reg, ones
      add_typed(OP_NOP,           8'hFF, tvp_pkg::KIND_ACK, 4'd0, 8'h00);
      add(tvp_pkg::OP_RENDER, 8'h00, 8'd0);                        // all-zero memory
      add(tvp_pkg::OP_RENDER, 8'h00, 8'd255);                      // line past visible area
      add(tvp_pkg::OP_CTRL, 8'h00, 8'h00);
      add(tvp_pkg::OP_CTRL, 8'hE0, 8'h00);                         // colour RAM, extra bits
      add_typed(tvp_pkg::OP_DATA, 8'hFF, tvp_pkg::KIND_ACK, 4'd0, 8'hFF);   // 6 bits kept
      add_typed(tvp_pkg::OP_DATA, 8'h2A, tvp_pkg::KIND_ACK, 4'd0, 8'h2A);
      add(tvp_pkg::OP_CTRL, 8'h00, 8'h00);
      add(tvp_pkg::OP_CTRL, 8'h78, 8'h00);                         // VRAM write at 0x3800
      add(tvp_pkg::OP_DATA, 8'h01, 8'h00);
      add(tvp_pkg::OP_DATA, 8'h02, 8'h00);                         // horizontal flip
      add(tvp_pkg::OP_RENDER, 8'h00, 8'd0);
      add(tvp_pkg::OP_CTRL, 8'hFF, 8'h00);
      add(tvp_pkg::OP_CTRL, 8'h7F, 8'h00);                         // write at 0x3FFF
      add(tvp_pkg::OP_DATA, 8'h55, 8'h00);
      add(tvp_pkg::OP_DATA, 8'h11, 8'h00);                         // address wrapped to 0
      add(tvp_pkg::OP_CTRL, 8'hFF, 8'h00);
      add_typed(tvp_pkg::OP_CTRL, 8'h3F, tvp_pkg::KIND_ACK, 4'd0, 8'h55);   // prefetch, wrap
      add(tvp_pkg::OP_DATA, 8'h9C, 8'h00);                         // data write, read code
      add(tvp_pkg::OP_CTRL, 8'h12, 8'h00);                         // lone first byte
      add(tvp_pkg::OP_DATA, 8'h34, 8'h00);                         // clears the pending byte
      n_directed = stim.size();
   endtask

   task automatic build_random();
      int sel, n;
      logic [13:0] a;
      logic [8:0]  pn;
      while (stim.size() < n_directed + N_RANDOM) begin
         sel = $urandom_range(0, 99);
         if (sel < 20) begin
            // nametable entries, mostly in the first rows
            a = NAME_BASE | (14'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 3)) << 6)
                          | (14'($urandom_range(0, 31)) << 1);
            set_addr(a, CODE_VRAMW);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
               add(tvp_pkg::OP_DATA, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 15)),
                   8'($urandom));
               add(tvp_pkg::OP_DATA, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 3)),
                   8'($urandom));
            end
         end else if (sel < 40) begin
            // tile pattern rows that the nametable points to
            pn = 9'($urandom_range(0, 15) | (($urandom_range(0, 1)) << 8));
            a  = {pn, 3'($urandom_range(0, 7)), 2'b00};
            set_addr(a, CODE_VRAMW);
            n = $urandom_range(4, 8);
            for (int i = 0; i < n; i++)
               add(tvp_pkg::OP_DATA, 8'($urandom), 8'($urandom));
         end else if (sel < 52) begin
            add(tvp_pkg::OP_CTRL, 8'($urandom), 8'($urandom));
            add(tvp_pkg::OP_CTRL, {tvp_pkg::CODE_CRAM, 6'($urandom)}, 8'($urandom));
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               add(tvp_pkg::OP_DATA, 8'($urandom), 8'($urandom));
         end else if (sel < 60) begin
            add(tvp_pkg::OP_CTRL, 8'($urandom), 8'($urandom));
            add(tvp_pkg::OP_CTRL, {tvp_pkg::CODE_READ, 6'($urandom)}, 8'($urandom));
            if ($urandom_range(0, 1) != 0)
               add(tvp_pkg::OP_DATA, 8'($urandom), 8'($urandom));
         end else if (sel < 66) begin
            add(tvp_pkg::OP_CTRL, 8'($urandom), 8'($urandom));
            add(tvp_pkg::OP_CTRL, {tvp_pkg::CODE_REGW, 6'($urandom)}, 8'($urandom));
         end else if (sel < 80) begin
            add(tvp_pkg::OP_RENDER, 8'($urandom),
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31)));
         end else begin
            add(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));   // noise
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Request side: bursts with random gaps, shadow model updated on acceptance
   // ---------------------------------------------------------------------------
   int burst_left = 0, gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            apply_request(stim[sent]);
            sent++;
            n_req++;
         end
         if (req_if.valid && !req_if.ready) begin
            // hold the offered transaction
         end else if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (sent < stim.size()) begin
            req_if.valid <= 1'b1;
            req_if.op    <= stim[sent].op;
            req_if.value <= stim[sent].value;
            req_if.line  <= stim[sent].line;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response side: stall pattern with stall-free stretches, one long hold-off
   // ---------------------------------------------------------------------------
   int stall_mode = 0, mode_left = 0, hold_left = 0;
   bit hold_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (!hold_done && n_req >= 150) begin
            hold_done = 1;
            hold_left = HOLD_LEN;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 2) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker and idle watchdog
   // ---------------------------------------------------------------------------
   video_rsp_type got, want;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_rsp.size());
            $display("TEST FAILED");
            $finish;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind       = rsp_if.kind;
            got.reg_index  = rsp_if.reg_index;
            got.byte_value = rsp_if.byte_value;
            got.pix        = {rsp_if.pix7, rsp_if.pix6, rsp_if.pix5, rsp_if.pix4,
                              rsp_if.pix3, rsp_if.pix2, rsp_if.pix1, rsp_if.pix0};
            got.last       = rsp_if.last;
            n_rsp++;
            if (pending_rsp.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %h at %0t", got, $realtime);
            end else begin
               want = pending_rsp.pop_front();
               if (got.kind !== want.kind || got.reg_index !== want.reg_index ||
                   got.byte_value !== want.byte_value || got.pix !== want.pix ||
                   got.last !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display({"result %0d mismatch: kind %0d/%0d reg %h/%h byte %h/%h ",
                               "pix %h/%h last %b/%b (exp/got)"}, n_rsp,
                              want.kind, got.kind, want.reg_index, got.reg_index,
                              want.byte_value, got.byte_value, want.pix, got.pix,
                              want.last, got.last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: reset, stimulus, drain, verdict
   // ---------------------------------------------------------------------------
   initial begin
      req_if.valid = 1'b0;
      req_if.op    = tvp_pkg::OP_CTRL;
      req_if.value = 8'd0;
      req_if.line  = 8'd0;
      rsp_if.ready = 1'b0;
      sh_pending = 1'b0;
      sh_code    = tvp_pkg::CODE_READ;
      sh_addr    = '0;
      sh_latch   = '0;
      foreach (sh_vram[i]) sh_vram[i] = '0;
      foreach (sh_cram[i]) sh_cram[i] = '0;
      build_directed();
      build_random();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (sent < stim.size() || pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);   // wait for any stray result
      $display("%0d requests (%0d line renders, %0d register writes), %0d results checked",
               n_req, n_renders, n_regw, n_rsp);
      $display("%0d mismatches", errors);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/tvp_pkg.sv
rtl/core/tvp_if.sv
rtl/core/tvp_ram.sv
rtl/core/tvp_datapath.sv
rtl/core/tvp_ctrl.sv
rtl/core/tile_video_port_and_line_fetch_core.sv
tb/tile_video_port_and_line_fetch_core_tb.sv
